### rtl/kdop26_slab_extent_unit_defines.svh
// Assertion macros shared by the k-DOP slab extent checker.
// Depends on nothing; included by kdop_checker.sv.
`ifndef KDOP26_SLAB_EXTENT_UNIT_DEFINES_SVH
`define KDOP26_SLAB_EXTENT_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset
`define KDOP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kdop check failed");

// Next-cycle implication, masked during reset
`define KDOP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kdop check failed");

// Next-cycle implication that also holds across reset
`define KDOP_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("kdop check failed");

`endif

### rtl/kdop_pkg.sv
// Shared types, constants and helpers of the k-DOP slab extent unit.
// No dependencies; imported by every module of the block.
package kdop_pkg;

    localparam int DATA_W        = 32;
    localparam int IDX_W         = 5;
    localparam int MARGIN_W      = 16;
    localparam int FRACTION_BITS = 8;
    localparam int DIR_MAX       = 26;

    // Margin reset: 0.1 rounded to the coordinate grid
    localparam logic [MARGIN_W-1:0] MARGIN_RESET =
        MARGIN_W'(((1 << FRACTION_BITS) * 10 + 50) / 100);

    // Diagonal coefficients, unsigned Q0.24
    localparam int                COEF_SHIFT  = 24;
    localparam logic [23:0]       COEF_EDGE   = 24'd11863283;
    localparam logic [23:0]       COEF_CORNER = 24'd9686330;

    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Register map
    localparam logic [2:0] ADDR_MARGIN = 3'd0;

    // Direction component signs
    localparam logic [1:0] SGN_ZERO = 2'b00;
    localparam logic [1:0] SGN_POS  = 2'b01;
    localparam logic [1:0] SGN_NEG  = 2'b11;

    // Direction kinds
    localparam logic [1:0] KIND_AXIS   = 2'd0;
    localparam logic [1:0] KIND_EDGE   = 2'd1;
    localparam logic [1:0] KIND_CORNER = 2'd2;

    typedef struct packed {
        logic [1:0] sx;
        logic [1:0] sy;
        logic [1:0] sz;
        logic [1:0] kind;
    } t_dir;

    // Snapshot queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Fixed direction table, in output order
    function automatic t_dir dir_entry(input logic [IDX_W-1:0] idx);
        t_dir d;
        case (idx)
            5'd0:  d = '{SGN_POS,  SGN_ZERO, SGN_ZERO, KIND_AXIS};
            5'd1:  d = '{SGN_NEG,  SGN_ZERO, SGN_ZERO, KIND_AXIS};
            5'd2:  d = '{SGN_ZERO, SGN_POS,  SGN_ZERO, KIND_AXIS};
            5'd3:  d = '{SGN_ZERO, SGN_NEG,  SGN_ZERO, KIND_AXIS};
            5'd4:  d = '{SGN_ZERO, SGN_ZERO, SGN_POS,  KIND_AXIS};
            5'd5:  d = '{SGN_ZERO, SGN_ZERO, SGN_NEG,  KIND_AXIS};
            5'd6:  d = '{SGN_ZERO, SGN_POS,  SGN_POS,  KIND_EDGE};
            5'd7:  d = '{SGN_ZERO, SGN_NEG,  SGN_NEG,  KIND_EDGE};
            5'd8:  d = '{SGN_ZERO, SGN_POS,  SGN_NEG,  KIND_EDGE};
            5'd9:  d = '{SGN_ZERO, SGN_NEG,  SGN_POS,  KIND_EDGE};
            5'd10: d = '{SGN_POS,  SGN_ZERO, SGN_POS,  KIND_EDGE};
            5'd11: d = '{SGN_NEG,  SGN_ZERO, SGN_NEG,  KIND_EDGE};
            5'd12: d = '{SGN_POS,  SGN_ZERO, SGN_NEG,  KIND_EDGE};
            5'd13: d = '{SGN_NEG,  SGN_ZERO, SGN_POS,  KIND_EDGE};
            5'd14: d = '{SGN_POS,  SGN_POS,  SGN_ZERO, KIND_EDGE};
            5'd15: d = '{SGN_NEG,  SGN_NEG,  SGN_ZERO, KIND_EDGE};
            5'd16: d = '{SGN_POS,  SGN_NEG,  SGN_ZERO, KIND_EDGE};
            5'd17: d = '{SGN_NEG,  SGN_POS,  SGN_ZERO, KIND_EDGE};
            5'd18: d = '{SGN_POS,  SGN_POS,  SGN_POS,  KIND_CORNER};
            5'd19: d = '{SGN_POS,  SGN_POS,  SGN_NEG,  KIND_CORNER};
            5'd20: d = '{SGN_POS,  SGN_NEG,  SGN_POS,  KIND_CORNER};
            5'd21: d = '{SGN_POS,  SGN_NEG,  SGN_NEG,  KIND_CORNER};
            5'd22: d = '{SGN_NEG,  SGN_POS,  SGN_POS,  KIND_CORNER};
            5'd23: d = '{SGN_NEG,  SGN_POS,  SGN_NEG,  KIND_CORNER};
            5'd24: d = '{SGN_NEG,  SGN_NEG,  SGN_POS,  KIND_CORNER};
            5'd25: d = '{SGN_NEG,  SGN_NEG,  SGN_NEG,  KIND_CORNER};
            default: d = '{SGN_ZERO, SGN_ZERO, SGN_ZERO, KIND_AXIS};
        endcase
        return d;
    endfunction

    // Clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < 64'shFFFF_FFFF_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/kdop26_slab_extent_unit.sv
// k-DOP slab extent unit: takes one vertex per cycle; a mesh's maxima pass
// the sum, scale and round registers, snapshot queue and output register,
// then its DIRECTION_COUNT results come out one per cycle while pop is held.
// Throughput is one vertex per cycle through the sum, scale and round stages;
// it pauses only when two finished meshes still wait in the snapshot queue.
// Reset is synchronous: maxima to the most negative value, margin to 0.1.
module kdop26_slab_extent_unit import kdop_pkg::*; #(
    parameter int DIRECTION_COUNT = 26
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [DATA_W-1:0] i_vertex_x,
    input  logic signed [DATA_W-1:0] i_vertex_y,
    input  logic signed [DATA_W-1:0] i_vertex_z,
    input  logic                     i_last_vertex,
    output logic                     empty,
    input  logic                     pop,
    output logic [IDX_W-1:0]         o_direction_index,
    output logic signed [DATA_W-1:0] o_slab_distance,
    output logic                     o_last_direction,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [MARGIN_W-1:0]                    r_margin;
    logic                                   w_cfg_wr;
    t_q_stat                                w_q_stat;
    logic                                   w_snap_push;
    logic [DIRECTION_COUNT-1:0][DATA_W-1:0] w_snap;
    logic [DIRECTION_COUNT-1:0][DATA_W-1:0] w_head;
    logic                                   w_q_pop;

    // Configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr == ADDR_MARGIN) ? 32'(r_margin) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (w_cfg_wr && (paddr == ADDR_MARGIN)) begin
            r_margin <= pwdata[MARGIN_W-1:0];
        end
    end

    kdop_front #(.DIRECTION_COUNT(DIRECTION_COUNT)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_vertex_z    (i_vertex_z),
        .i_last_vertex (i_last_vertex),
        .i_q_stat      (w_q_stat),
        .o_snap_push   (w_snap_push),
        .o_snap        (w_snap)
    );

    kdop_snapq #(.DIRECTION_COUNT(DIRECTION_COUNT)) u_snapq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_snap_push),
        .i_row   (w_snap),
        .i_pop   (w_q_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    kdop_back #(.DIRECTION_COUNT(DIRECTION_COUNT)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_stat          (w_q_stat),
        .i_head            (w_head),
        .i_margin          (r_margin),
        .o_q_pop           (w_q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_direction_index (o_direction_index),
        .o_slab_distance   (o_slab_distance),
        .o_last_direction  (o_last_direction)
    );

endmodule

### rtl/kdop_front.sv
// Front end: accepts vertices, projects them onto the k-DOP directions and
// keeps the running maxima; pushes a snapshot on the last vertex. Uses kdop_pkg.
module kdop_front import kdop_pkg::*; #(
    parameter int DIRECTION_COUNT = 26
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic signed [DATA_W-1:0]               i_vertex_x,
    input  logic signed [DATA_W-1:0]               i_vertex_y,
    input  logic signed [DATA_W-1:0]               i_vertex_z,
    input  logic                                   i_last_vertex,
    input  t_q_stat                                i_q_stat,
    output logic                                   o_snap_push,
    output logic [DIRECTION_COUNT-1:0][DATA_W-1:0] o_snap
);

    localparam int SUM_W  = DATA_W + 2;
    localparam int PROD_W = SUM_W + 25;
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (COEF_SHIFT - 1);

    logic r_v1, r_v2, r_v3;
    logic r_last1, r_last2, r_last3;
    logic w_stall;

    // Signed contribution of one coordinate to a direction sum
    function automatic logic signed [SUM_W-1:0] term(input logic [1:0] sg,
                                                     input logic signed [DATA_W-1:0] v);
        logic signed [SUM_W-1:0] e;
        logic signed [SUM_W-1:0] r;
        e = {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
        case (sg)
            SGN_POS: r = e;
            SGN_NEG: r = -e;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Hold the whole pipe while a last vertex waits for queue space
    assign w_stall     = r_v3 && r_last3 && i_q_stat.full;
    assign o_full      = w_stall;
    assign o_snap_push = r_v3 && r_last3 && !w_stall;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (!w_stall) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Advance last markers
    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_last1 <= i_last_vertex;
            r_last2 <= r_last1;
            r_last3 <= r_last2;
        end
    end

    for (genvar g = 0; g < DIRECTION_COUNT; g++) begin : g_dir
        localparam t_dir D = dir_entry(IDX_W'(g));

        logic signed [SUM_W-1:0]  r_sum1;
        logic signed [PROD_W-1:0] r_prod2;
        logic signed [DATA_W-1:0] r_proj3;
        logic signed [DATA_W-1:0] r_acc;
        logic signed [PROD_W-1:0] w_scaled;
        logic signed [DATA_W-1:0] w_proj;
        logic signed [DATA_W-1:0] w_max;

        // Scale diagonals by their coefficient, pass axes through
        if (D.kind == KIND_AXIS) begin : g_axis
            assign w_scaled = {{(PROD_W-SUM_W){r_sum1[SUM_W-1]}}, r_sum1};
            assign w_proj   = sat32({{(64-PROD_W){r_prod2[PROD_W-1]}}, r_prod2});
        end else begin : g_diag
            localparam logic signed [24:0] COEF =
                (D.kind == KIND_EDGE) ? {1'b0, COEF_EDGE} : {1'b0, COEF_CORNER};
            logic signed [PROD_W-1:0] w_rnd;
            assign w_scaled = r_sum1 * COEF;
            // Round to nearest, ties up
            assign w_rnd  = (r_prod2 + HALF_LSB) >>> COEF_SHIFT;
            assign w_proj = sat32({{(64-PROD_W){w_rnd[PROD_W-1]}}, w_rnd});
        end

        assign w_max     = (r_proj3 > r_acc) ? r_proj3 : r_acc;
        assign o_snap[g] = w_max;

        // Sum, scale, round stages
        always_ff @(posedge i_clk) begin
            if (!w_stall) begin
                r_sum1  <= term(D.sx, i_vertex_x) + term(D.sy, i_vertex_y)
                         + term(D.sz, i_vertex_z);
                r_prod2 <= w_scaled;
                r_proj3 <= w_proj;
            end
        end

        // Running maximum; restart after the last vertex
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc <= S32_MIN;
            end else if (r_v3 && !w_stall) begin
                r_acc <= r_last3 ? S32_MIN : w_max;
            end
        end
    end

endmodule

### rtl/kdop_snapq.sv
// Two-entry queue of finished maxima snapshots between front and back.
// Uses kdop_pkg for widths and the status struct.
module kdop_snapq import kdop_pkg::*; #(
    parameter int DIRECTION_COUNT = 26
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  logic [DIRECTION_COUNT-1:0][DATA_W-1:0] i_row,
    input  logic                                   i_pop,
    output logic [DIRECTION_COUNT-1:0][DATA_W-1:0] o_head,
    output t_q_stat                                o_stat
);

    logic [DIRECTION_COUNT-1:0][DATA_W-1:0] r_row [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_head       = r_row[r_rd_ptr];

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Store a snapshot row
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_row[r_wr_ptr] <= i_row;
        end
    end

endmodule

### rtl/kdop_back.sv
// Back end: walks the head snapshot one direction per cycle while pop is held,
// adds the margin with saturation and registers each result. Uses kdop_pkg.
module kdop_back import kdop_pkg::*; #(
    parameter int DIRECTION_COUNT = 26
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_q_stat                                i_q_stat,
    input  logic [DIRECTION_COUNT-1:0][DATA_W-1:0] i_head,
    input  logic [MARGIN_W-1:0]                    i_margin,
    output logic                                   o_q_pop,
    input  logic                                   i_pop,
    output logic                                   o_empty,
    output logic [IDX_W-1:0]                       o_direction_index,
    output logic signed [DATA_W-1:0]               o_slab_distance,
    output logic                                   o_last_direction
);

    localparam int SEL_W = $clog2(DIRECTION_COUNT);
    localparam logic [SEL_W-1:0] LAST_POS = SEL_W'(DIRECTION_COUNT - 1);

    logic [SEL_W-1:0]         r_pos;
    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_idx;
    logic signed [DATA_W-1:0] r_out_dist;
    logic                     r_out_last;
    logic                     w_load;
    logic                     w_at_last;
    logic signed [DATA_W-1:0] w_word;
    logic signed [63:0]       w_sum;

    // Load a new result when the output slot frees up
    assign w_load    = !i_q_stat.empty && (!r_out_valid || i_pop);
    assign w_at_last = (r_pos == LAST_POS);
    assign o_q_pop   = w_load && w_at_last;

    assign w_word = i_head[r_pos];
    assign w_sum  = {{(64-DATA_W){w_word[DATA_W-1]}}, w_word} + 64'(i_margin);

    // Step through directions of the head snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_pos <= w_at_last ? '0 : r_pos + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx  <= IDX_W'(r_pos);
            r_out_dist <= sat32(w_sum);
            r_out_last <= w_at_last;
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_direction_index = r_out_idx;
    assign o_slab_distance   = r_out_dist;
    assign o_last_direction  = r_out_last;

endmodule

### rtl/kdop_checker.sv
// Port-level checks on the result side of the k-DOP slab extent unit.
// Uses kdop_pkg and the macros of kdop26_slab_extent_unit_defines.svh.
`include "kdop26_slab_extent_unit_defines.svh"

module kdop_checker import kdop_pkg::*; #(
    parameter int DIRECTION_COUNT = 26
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     empty,
    input logic                     pop,
    input logic [IDX_W-1:0]         o_direction_index,
    input logic signed [DATA_W-1:0] o_slab_distance,
    input logic                     o_last_direction
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIRECTION_COUNT - 1);

    // Results drain away in reset
    `KDOP_ASSERT_NEXT_ANY(a_reset_empty, i_clk, !i_rst_n, empty)

    // The run ends on the final direction
    `KDOP_ASSERT_NOW(a_last_idx, i_clk, i_rst_n, !empty && o_last_direction, o_direction_index == LAST_IDX)

    // Directions come out in table order
    `KDOP_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, !empty && pop && !o_last_direction, empty || (o_direction_index == IDX_W'($past(o_direction_index) + 1'b1)))

    // A waiting result holds
    `KDOP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_slab_distance) && $stable(o_direction_index))

endmodule

bind kdop26_slab_extent_unit kdop_checker #(.DIRECTION_COUNT(DIRECTION_COUNT)) u_kdop_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .empty             (empty),
    .pop               (pop),
    .o_direction_index (o_direction_index),
    .o_slab_distance   (o_slab_distance),
    .o_last_direction  (o_last_direction)
);
